[rtl/core/jac_pkg.sv]
package jac_pkg;

  localparam int NUM_OUT = 4;
  localparam int LANE_W = 2;
  localparam int CFG_W = 64;
  // signed width of a post-clamp offset or of a span width
  localparam int CW = 18;
  localparam int QW = 2 * CW;
  localparam int DIV_STEPS = QW / 2;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {
    REG_HYST   = 3'd0,
    REG_CENTER = 3'd1,
    REG_LOW    = 3'd2,
    REG_HIGH   = 3'd3,
    REG_DEAD   = 3'd4,
    REG_CALIB  = 3'd5,
    REG_COUNT  = 3'd6,
    REG_ORDER  = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [CFG_W-1:0] hyst;
    logic [CFG_W-1:0] center;
    logic [CFG_W-1:0] low_lim;
    logic [CFG_W-1:0] high_lim;
    logic [CFG_W-1:0] dead;
    logic             calib;
    logic [2:0]       axis_count;
    logic [7:0]       out_order;
  } cfg_t;

  typedef struct packed {
    logic [LANE_W-1:0] lane;
    logic              lane_ok;
    logic              last;
    logic              scale;
  } job_ctrl_t;

  function automatic logic [15:0] lane16(input logic [CFG_W-1:0] r,
                                         input logic [LANE_W-1:0] k);
    lane16 = r[16*k +: 16];
  endfunction

endpackage

[rtl/core/joystick_axis_conditioner_top.sv]
// Joystick axis conditioner. Each pushed item is one poll of the raw axes; one
// result of four signed values comes out per item, in order. The front stage
// takes an item when full is low and emits one lane job per cycle while the job
// queue is not full (hysteresis, dead zone, clamp and offset are resolved there);
// a two-entry job queue feeds the back stage, which scales, saturates and
// reorders. There an unscaled lane goes from pop straight to store; a scaled lane
// gets one multiply, then a shared divider retiring 2 quotient bits a cycle until
// all 36 are out (skipped when the divisor is zero), then the store. After the
// last lane the result goes to the two-entry result queue. Configuration writes
// take effect at once and must only be made while no item is in flight.
module joystick_axis_conditioner_top #(
  parameter int AXIS_LANES = 4,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [2:0]                    cfg_idx_i,
  input  logic [jac_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          push,
  output logic                          full,
  input  logic [SAMPLE_BITS-1:0]        axis_a_i,
  input  logic [SAMPLE_BITS-1:0]        axis_b_i,
  input  logic [SAMPLE_BITS-1:0]        axis_c_i,
  input  logic [SAMPLE_BITS-1:0]        axis_d_i,
  output logic                          empty,
  input  logic                          pop,
  output logic signed [SAMPLE_BITS:0]   out_a_o,
  output logic signed [SAMPLE_BITS:0]   out_b_o,
  output logic signed [SAMPLE_BITS:0]   out_c_o,
  output logic signed [SAMPLE_BITS:0]   out_d_o
);
  import jac_pkg::*;

  localparam int DW = (SAMPLE_BITS + 1 > CW) ? SAMPLE_BITS + 1 : CW;
  localparam int JOB_W = $bits(job_ctrl_t) + DW + 2 * CW;
  localparam int SW = SAMPLE_BITS + 1;
  localparam int RES_W = NUM_OUT * SW;

  cfg_t cfg_q;

  logic [3:0][SAMPLE_BITS-1:0]  all_axes;
  logic                         job_push, job_full, job_pop, job_empty;
  job_ctrl_t                    job_ctrl_w, job_ctrl_r;
  logic signed [DW-1:0]         job_val_w, job_val_r;
  logic signed [CW-1:0]         job_mul_w, job_mul_r, job_div_w, job_div_r;
  logic [JOB_W-1:0]             job_wdata, job_rdata;
  logic                         res_push, res_full;
  logic [NUM_OUT-1:0][SAMPLE_BITS:0] res_vec;
  logic [RES_W-1:0]             res_wdata, res_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hyst       <= '0;
      cfg_q.center     <= '0;
      cfg_q.low_lim    <= '0;
      cfg_q.high_lim   <= '1;
      cfg_q.dead       <= '0;
      cfg_q.calib      <= 1'b0;
      cfg_q.axis_count <= 3'd4;
      cfg_q.out_order  <= 8'd228;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_HYST:   cfg_q.hyst       <= cfg_data_i;
        REG_CENTER: cfg_q.center     <= cfg_data_i;
        REG_LOW:    cfg_q.low_lim    <= cfg_data_i;
        REG_HIGH:   cfg_q.high_lim   <= cfg_data_i;
        REG_DEAD:   cfg_q.dead       <= cfg_data_i;
        REG_CALIB:  cfg_q.calib      <= cfg_data_i[0];
        REG_COUNT:  cfg_q.axis_count <= cfg_data_i[2:0];
        REG_ORDER:  cfg_q.out_order  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign all_axes = {axis_d_i, axis_c_i, axis_b_i, axis_a_i};

  jac_front #(
    .AXIS_LANES  (AXIS_LANES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .push_i     (push),
    .full_o     (full),
    .axis_i     (all_axes[AXIS_LANES-1:0]),
    .job_push_o (job_push),
    .job_full_i (job_full),
    .job_ctrl_o (job_ctrl_w),
    .job_val_o  (job_val_w),
    .job_mul_o  (job_mul_w),
    .job_div_o  (job_div_w)
  );

  assign job_wdata = {job_ctrl_w, job_val_w, job_mul_w, job_div_w};
  assign {job_ctrl_r, job_val_r, job_mul_r, job_div_r} = job_rdata;

  jac_fifo #(
    .WIDTH (JOB_W),
    .DEPTH (2)
  ) u_job_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .full_o  (job_full),
    .wdata_i (job_wdata),
    .pop_i   (job_pop),
    .empty_o (job_empty),
    .rdata_o (job_rdata)
  );

  jac_back #(
    .AXIS_LANES  (AXIS_LANES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_empty_i (job_empty),
    .job_pop_o   (job_pop),
    .job_ctrl_i  (job_ctrl_r),
    .job_val_i   (job_val_r),
    .job_mul_i   (job_mul_r),
    .job_div_i   (job_div_r),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_vec)
  );

  assign res_wdata = res_vec;

  jac_fifo #(
    .WIDTH (RES_W),
    .DEPTH (2)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .full_o  (res_full),
    .wdata_i (res_wdata),
    .pop_i   (pop),
    .empty_o (empty),
    .rdata_o (res_rdata)
  );

  assign out_a_o = res_rdata[0*SW +: SW];
  assign out_b_o = res_rdata[1*SW +: SW];
  assign out_c_o = res_rdata[2*SW +: SW];
  assign out_d_o = res_rdata[3*SW +: SW];

endmodule

[rtl/core/jac_fifo.sv]
module jac_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] rdata_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

[rtl/core/jac_front.sv]
module jac_front #(
  parameter int AXIS_LANES = 4,
  parameter int SAMPLE_BITS = 16,
  localparam int DW = (SAMPLE_BITS + 1 > jac_pkg::CW) ? SAMPLE_BITS + 1 : jac_pkg::CW
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  jac_pkg::cfg_t                          cfg_i,
  input  logic                                   push_i,
  output logic                                   full_o,
  input  logic [AXIS_LANES-1:0][SAMPLE_BITS-1:0] axis_i,
  output logic                                   job_push_o,
  input  logic                                   job_full_i,
  output jac_pkg::job_ctrl_t                     job_ctrl_o,
  output logic signed [DW-1:0]                   job_val_o,
  output logic signed [jac_pkg::CW-1:0]          job_mul_o,
  output logic signed [jac_pkg::CW-1:0]          job_div_o
);
  import jac_pkg::*;

  localparam int IDX_W = (AXIS_LANES > 1) ? $clog2(AXIS_LANES) : 1;
  localparam int VW = ((SAMPLE_BITS > 16) ? SAMPLE_BITS : 16) + 2;

  logic                                   busy_q;
  logic [LANE_W-1:0]                      lane_q;
  logic [2:0]                             n_q;
  logic [AXIS_LANES-1:0][SAMPLE_BITS-1:0] raw_q;
  logic [AXIS_LANES-1:0][SAMPLE_BITS-1:0] held_q;

  logic [IDX_W-1:0]       idx;
  logic [SAMPLE_BITS-1:0] v, h, vh;
  logic [15:0]            hy, c, dz, lo, hi, vc;
  logic [VW-1:0]          vx;
  logic                   take, in_dead, below;
  logic signed [CW-1:0]   cs, dzs, los, his, vcs, w1, w2, d;
  logic                   accept;

  assign accept = push_i && !full_o;
  assign full_o = busy_q;
  assign job_push_o = busy_q && !job_full_i;
  assign idx = lane_q[IDX_W-1:0];

  always_comb begin
    v  = raw_q[idx];
    h  = held_q[idx];
    hy = lane16(cfg_i.hyst, lane_q);
    c  = lane16(cfg_i.center, lane_q);
    dz = lane16(cfg_i.dead, lane_q);
    lo = lane16(cfg_i.low_lim, lane_q);
    hi = lane16(cfg_i.high_lim, lane_q);

    // movement filter: take the new value only past the threshold
    if (VW'(v) > VW'(h)) begin
      take = VW'(v) > VW'(h) + VW'(hy[7:0]);
    end else begin
      take = VW'(v) + VW'(hy[15:8]) < VW'(h);
    end
    vh = take ? v : h;
    vx = VW'(vh);

    in_dead = (vx + VW'(dz) >= VW'(c)) && (vx <= VW'(c) + VW'(dz));

    if (vx < VW'(lo)) begin
      vc = lo;
    end else if (vx > VW'(hi)) begin
      vc = hi;
    end else begin
      vc = vx[15:0];
    end

    cs  = CW'(c);
    dzs = CW'(dz);
    los = CW'(lo);
    his = CW'(hi);
    vcs = CW'(vc);
    w1  = cs - dzs - los;
    w2  = his - cs - dzs;
    below = (vc < c);
    d = below ? (vcs - cs + dzs) : (vcs - cs - dzs);

    job_ctrl_o.lane    = lane_q;
    job_ctrl_o.lane_ok = (n_q != 3'd0);
    job_ctrl_o.last    = (n_q == 3'd0) || ({1'b0, lane_q} == n_q - 3'd1);
    job_ctrl_o.scale   = 1'b0;
    job_val_o = '0;
    job_mul_o = below ? w2 : w1;
    job_div_o = below ? w1 : w2;
    if (n_q == 3'd0) begin
      job_val_o = '0;
    end else if (!cfg_i.calib) begin
      job_val_o = DW'(v);
    end else if (in_dead) begin
      job_val_o = '0;
    end else begin
      job_val_o = DW'(d);
      job_ctrl_o.scale = below ? (w1 > w2) : (w2 > w1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      raw_q <= axis_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      lane_q <= '0;
      n_q    <= '0;
      held_q <= '0;
    end else begin
      if (accept) begin
        busy_q <= 1'b1;
        lane_q <= '0;
        n_q    <= (cfg_i.axis_count > 3'(AXIS_LANES)) ? 3'(AXIS_LANES) : cfg_i.axis_count;
      end else if (job_push_o) begin
        lane_q <= lane_q + 1'b1;
        if (job_ctrl_o.last) begin
          busy_q <= 1'b0;
        end
        if (cfg_i.calib && (n_q != 3'd0) && take) begin
          held_q[idx] <= v;
        end
      end
    end
  end

  a_held_only_calib: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(held_q) |-> ($past(cfg_i.calib) && $past(busy_q)))
    else $error("held value moved outside a calibrated item");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (busy_q && lane_q == '0))
    else $error("accepted item did not start at lane zero");

endmodule

[rtl/core/jac_back.sv]
module jac_back #(
  parameter int AXIS_LANES = 4,
  parameter int SAMPLE_BITS = 16,
  localparam int DW = (SAMPLE_BITS + 1 > jac_pkg::CW) ? SAMPLE_BITS + 1 : jac_pkg::CW
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  jac_pkg::cfg_t                               cfg_i,
  input  logic                                        job_empty_i,
  output logic                                        job_pop_o,
  input  jac_pkg::job_ctrl_t                          job_ctrl_i,
  input  logic signed [DW-1:0]                        job_val_i,
  input  logic signed [jac_pkg::CW-1:0]               job_mul_i,
  input  logic signed [jac_pkg::CW-1:0]               job_div_i,
  input  logic                                        res_full_i,
  output logic                                        res_push_o,
  output logic [jac_pkg::NUM_OUT-1:0][SAMPLE_BITS:0]  res_o
);
  import jac_pkg::*;

  localparam int RW = (DW > QW + 1) ? DW : QW + 1;
  localparam logic signed [RW-1:0] LIM = RW'((64'd1 << SAMPLE_BITS) - 64'd1);
  localparam logic signed [RW-1:0] NLIM = -LIM;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_PREP, S_DIV, S_STORE, S_EMIT
  } state_e;

  state_e                             state_q;
  job_ctrl_t                          ctrl_q;
  logic signed [DW-1:0]               val_q;
  logic signed [CW-1:0]               mul_q, div_q;
  logic signed [QW-1:0]               prod_q;
  logic [CW-1:0]                      rem_q, den_q;
  logic [QW-1:0]                      quo_q;
  logic                               neg_q;
  logic [DIV_CNT_W-1:0]               cnt_q;
  logic signed [RW-1:0]               res_q;
  logic [NUM_OUT-1:0][SAMPLE_BITS:0]  out_q;

  logic signed [CW-1:0]  mul_a;
  logic [CW+QW-1:0]      step;
  logic [SAMPLE_BITS:0]  sat;

  // two restoring division steps per call
  function automatic logic [CW+QW-1:0] div2(input logic [CW-1:0] rem,
                                            input logic [QW-1:0] quo,
                                            input logic [CW-1:0] den);
    logic [CW:0]   r;
    logic [CW-1:0] rm;
    logic [QW-1:0] q;
    rm = rem;
    q  = quo;
    for (int i = 0; i < 2; i++) begin
      r = {rm, q[QW-1]};
      q = {q[QW-2:0], 1'b0};
      if (r >= {1'b0, den}) begin
        r = r - {1'b0, den};
        q[0] = 1'b1;
      end
      rm = r[CW-1:0];
    end
    div2 = {rm, q};
  endfunction

  assign job_pop_o  = (state_q == S_IDLE) && !job_empty_i;
  assign res_push_o = (state_q == S_EMIT) && !res_full_i;
  assign res_o      = out_q;
  assign mul_a      = val_q[CW-1:0];
  assign step       = div2(rem_q, quo_q, den_q);

  always_comb begin
    if (res_q > LIM) begin
      sat = LIM[SAMPLE_BITS:0];
    end else if (res_q < NLIM) begin
      sat = NLIM[SAMPLE_BITS:0];
    end else begin
      sat = res_q[SAMPLE_BITS:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      out_q   <= '0;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (job_pop_o) begin
            ctrl_q  <= job_ctrl_i;
            val_q   <= job_val_i;
            mul_q   <= job_mul_i;
            div_q   <= job_div_i;
            res_q   <= RW'(job_val_i);
            state_q <= job_ctrl_i.scale ? S_MUL : S_STORE;
          end
        end
        S_MUL: begin
          prod_q  <= mul_a * mul_q;
          state_q <= S_PREP;
        end
        S_PREP: begin
          if (div_q == '0) begin
            res_q   <= '0;
            state_q <= S_STORE;
          end else begin
            quo_q   <= prod_q[QW-1] ? QW'(-prod_q) : QW'(prod_q);
            den_q   <= div_q[CW-1] ? CW'(-div_q) : CW'(div_q);
            rem_q   <= '0;
            neg_q   <= prod_q[QW-1] ^ div_q[CW-1];
            cnt_q   <= '0;
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          rem_q <= step[CW+QW-1:QW];
          quo_q <= step[QW-1:0];
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
            // truncate toward zero: divide magnitudes, then restore the sign
            res_q   <= neg_q ? -RW'(step[QW-1:0]) : RW'(step[QW-1:0]);
            state_q <= S_STORE;
          end
        end
        S_STORE: begin
          for (int j = 0; j < NUM_OUT; j++) begin
            if (ctrl_q.lane_ok &&
                (cfg_i.calib ? (cfg_i.out_order[2*j +: 2] == ctrl_q.lane)
                             : (LANE_W'(j) == ctrl_q.lane))) begin
              out_q[j] <= sat;
            end
          end
          state_q <= ctrl_q.last ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          if (!res_full_i) begin
            out_q   <= '0;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_direct_to_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (job_pop_o && !job_ctrl_i.scale) |=> (state_q == S_STORE))
    else $error("unscaled item did not go straight to store");

  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (cnt_q <= DIV_CNT_W'(DIV_STEPS - 1)))
    else $error("divider ran past its step count");

  a_slots_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |=> (out_q == '0))
    else $error("output slots not cleared after an item");

endmodule
